// ===== rtl/assert_macros.svh =====
// assertion macros used by awa_ctrl
// no dependencies; each file that asserts includes this header
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every rising clock edge outside reset
`define AWA_CHECK(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("check failed");

// condition in one cycle implies a result in the next
`define AWA_CHECK_NEXT(name, clk, rst_n, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("check failed");

`endif

// ===== rtl/awa_pkg.sv =====
// shared types and constants of the airtime window accumulator
// no dependencies
package awa_pkg;

    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_QUERY  = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [15:0] SAT16 = 16'hFFFF;
    localparam logic [21:0] SAT22 = 22'h3FFFFF;
    localparam int unsigned ADDR_W = 8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROLL,
        S_RD_HEAD,
        S_ADD,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [15:0]       wtx;
        logic [15:0]       wrx;
        logic [ADDR_W-1:0] raddr;
        logic              clr_all;
    } t_ring_cmd;

    typedef struct packed {
        logic [15:0] tx;
        logic [15:0] rx;
    } t_ring_rd;

endpackage

// ===== rtl/awa_ring.sv =====
// bucket ring storage: tx/rx memories with per-entry valid bits
// depends on awa_pkg
module awa_ring import awa_pkg::*; #(
    parameter int NUM_BUCKETS = 60
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ring_cmd i_cmd,
    output t_ring_rd  o_rd
);

    localparam int AW = $clog2(NUM_BUCKETS);

    logic [15:0] r_mem_tx [NUM_BUCKETS];
    logic [15:0] r_mem_rx [NUM_BUCKETS];
    logic [NUM_BUCKETS-1:0] r_valid;
    logic [15:0] r_rd_tx;
    logic [15:0] r_rd_rx;
    logic        r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem_tx[i_cmd.waddr[AW-1:0]] <= i_cmd.wtx;
            r_mem_rx[i_cmd.waddr[AW-1:0]] <= i_cmd.wrx;
        end
        r_rd_tx <= r_mem_tx[i_cmd.raddr[AW-1:0]];
        r_rd_rx <= r_mem_rx[i_cmd.raddr[AW-1:0]];
    end

    // never-written entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_valid[i_cmd.raddr[AW-1:0]];
            if (i_cmd.clr_all) begin
                r_valid <= '0;
            end else if (i_cmd.we) begin
                r_valid[i_cmd.waddr[AW-1:0]] <= 1'b1;
            end
        end
    end

    assign o_rd.tx = r_rd_vld ? r_rd_tx : 16'd0;
    assign o_rd.rx = r_rd_vld ? r_rd_rx : 16'd0;

endmodule

// ===== rtl/awa_ctrl.sv =====
// sequencer: roll, bank and scan over the ring
// depends on awa_pkg, assert_macros.svh
`include "assert_macros.svh"
module awa_ctrl import awa_pkg::*; #(
    parameter int NUM_BUCKETS = 60
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_len,
    input  logic        i_start,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_now_ms,
    input  logic [31:0] i_total_tx_ms,
    input  logic [31:0] i_total_rx_ms,
    input  logic [7:0]  i_bucket_index,
    input  logic        i_stacked_max,
    input  t_ring_rd    i_rd,
    output t_ring_cmd   o_ring,
    output logic        o_busy,
    output logic        o_valid,
    output logic [15:0] o_tx_bucket_ms,
    output logic [15:0] o_rx_bucket_ms,
    output logic [21:0] o_tx_window_ms,
    output logic [21:0] o_rx_window_ms,
    output logic [15:0] o_max_bucket_ms,
    output logic        o_history_wiped
);

    localparam int AW = $clog2(NUM_BUCKETS);
    localparam int SW = 16 + AW;
    localparam logic [AW-1:0] LAST = AW'(NUM_BUCKETS - 1);
    localparam logic [8:0] NB9 = 9'(NUM_BUCKETS);

    t_state r_state, n_state;
    logic [AW-1:0] r_head, r_cnt, r_k, r_pk;
    logic          r_base_set, r_pv, r_stk, r_wiped;
    logic [31:0]   r_begin, r_prev_tx, r_prev_rx, r_rem, r_now;
    logic [15:0]   r_dtx, r_drx, r_btx, r_brx;
    logic [7:0]    r_idx;
    logic [SW-1:0] r_txs, r_rxs;
    logic [16:0]   r_mx;

    logic          accept, step, idx_ok;
    logic [AW-1:0] head_nx, slot;
    logic [8:0]    slot_sum;
    logic [31:0]   dtx_full, drx_full;
    logic [16:0]   add_tx, add_rx, v;

    assign accept  = i_start && (r_state == S_IDLE);
    assign step    = (r_rem >= i_len);
    assign head_nx = (r_head == LAST) ? '0 : r_head + AW'(1);
    assign idx_ok  = (9'(r_idx) < NB9);
    assign slot_sum = 9'(r_head) + 9'(r_idx) + 9'd1;
    always_comb begin
        slot = AW'(slot_sum);
        if (slot_sum >= NB9) begin
            slot = AW'(slot_sum - NB9);
        end
    end

    assign dtx_full = (i_total_tx_ms >= r_prev_tx) ? i_total_tx_ms - r_prev_tx : 32'd0;
    assign drx_full = (i_total_rx_ms >= r_prev_rx) ? i_total_rx_ms - r_prev_rx : 32'd0;
    assign add_tx = 17'(i_rd.tx) + 17'(r_dtx);
    assign add_rx = 17'(i_rd.rx) + 17'(r_drx);
    assign v = r_stk ? 17'(i_rd.tx) + 17'(i_rd.rx)
                     : ((i_rd.rx > i_rd.tx) ? 17'(i_rd.rx) : 17'(i_rd.tx));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_cmd == CMD_SAMPLE && r_base_set) n_state = S_ROLL;
                    else n_state = S_SCAN;
                end
            end
            S_ROLL: begin
                if (step && r_cnt == LAST) n_state = S_SCAN;
                else if (!step) n_state = S_RD_HEAD;
            end
            S_RD_HEAD: n_state = S_ADD;
            S_ADD:     n_state = S_SCAN;
            S_SCAN: begin
                if (r_k == LAST) n_state = S_DRAIN;
            end
            S_DRAIN:   n_state = S_DONE;
            S_DONE:    n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // ring port and handshake outputs
    always_comb begin
        o_ring = '0;
        unique case (r_state)
            S_IDLE: o_ring.clr_all = accept && (i_cmd == CMD_CLEAR);
            S_ROLL: begin
                if (step) begin
                    if (r_cnt == LAST) begin
                        o_ring.clr_all = 1'b1;
                    end else begin
                        o_ring.we    = 1'b1;
                        o_ring.waddr = ADDR_W'(head_nx);
                    end
                end
            end
            S_RD_HEAD: o_ring.raddr = ADDR_W'(r_head);
            S_ADD: begin
                o_ring.we    = 1'b1;
                o_ring.waddr = ADDR_W'(r_head);
                o_ring.wtx   = add_tx[16] ? SAT16 : add_tx[15:0];
                o_ring.wrx   = add_rx[16] ? SAT16 : add_rx[15:0];
            end
            S_SCAN: o_ring.raddr = ADDR_W'(r_k);
            default: ;
        endcase
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_head     <= '0;
            r_base_set <= 1'b0;
            r_begin    <= '0;
            r_prev_tx  <= '0;
            r_prev_rx  <= '0;
            r_cnt      <= '0;
            r_k        <= '0;
            r_pv       <= 1'b0;
            r_wiped    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= (r_state == S_SCAN);
            r_pk    <= r_k;
            unique case (r_state)
                S_IDLE: begin
                    r_k <= '0;
                    if (accept) begin
                        r_idx   <= i_bucket_index;
                        r_stk   <= i_stacked_max;
                        r_now   <= i_now_ms;
                        r_wiped <= 1'b0;
                        r_cnt   <= '0;
                        if (i_cmd == CMD_CLEAR) begin
                            r_head     <= '0;
                            r_base_set <= 1'b0;
                            r_begin    <= '0;
                            r_prev_tx  <= '0;
                            r_prev_rx  <= '0;
                        end else if (i_cmd == CMD_SAMPLE) begin
                            r_prev_tx <= i_total_tx_ms;
                            r_prev_rx <= i_total_rx_ms;
                            if (!r_base_set) begin
                                r_base_set <= 1'b1;
                                r_begin    <= i_now_ms;
                            end else begin
                                r_rem <= i_now_ms - r_begin;
                                r_dtx <= (dtx_full > 32'(SAT16)) ? SAT16 : dtx_full[15:0];
                                r_drx <= (drx_full > 32'(SAT16)) ? SAT16 : drx_full[15:0];
                            end
                        end
                    end
                end
                S_ROLL: begin
                    if (step) begin
                        if (r_cnt == LAST) begin
                            // whole window elapsed: wipe and restart the bucket clock
                            r_head  <= '0;
                            r_begin <= r_now;
                            r_wiped <= 1'b1;
                        end else begin
                            r_rem   <= r_rem - i_len;
                            r_begin <= r_begin + i_len;
                            r_head  <= head_nx;
                            r_cnt   <= r_cnt + AW'(1);
                        end
                    end
                end
                S_SCAN: r_k <= r_k + ((r_k == LAST) ? AW'(0) : AW'(1));
                default: ;
            endcase
        end
    end

    // scan accumulators, cleared while idle; the maximum starts at one
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_txs <= '0;
            r_rxs <= '0;
            r_mx  <= 17'd1;
            r_btx <= '0;
            r_brx <= '0;
        end else if (r_pv) begin
            r_txs <= r_txs + SW'(i_rd.tx);
            r_rxs <= r_rxs + SW'(i_rd.rx);
            if (v > r_mx) r_mx <= v;
            if (idx_ok && r_pk == slot) begin
                r_btx <= i_rd.tx;
                r_brx <= i_rd.rx;
            end
        end
    end

    assign o_tx_bucket_ms  = r_btx;
    assign o_rx_bucket_ms  = r_brx;
    assign o_tx_window_ms  = (32'(r_txs) > 32'(SAT22)) ? SAT22 : 22'(r_txs);
    assign o_rx_window_ms  = (32'(r_rxs) > 32'(SAT22)) ? SAT22 : 22'(r_rxs);
    assign o_max_bucket_ms = r_mx[16] ? SAT16 : r_mx[15:0];
    assign o_history_wiped = r_wiped;

    `AWA_CHECK(a_no_clr_and_write, i_clk, i_rst_n, !(o_ring.clr_all && o_ring.we))
    `AWA_CHECK(a_head_in_range, i_clk, i_rst_n, 9'(r_head) < NB9)
    `AWA_CHECK_NEXT(a_done_to_idle, i_clk, i_rst_n, r_state == S_DONE, !o_busy)
    `AWA_CHECK_NEXT(a_wipe_resets_head, i_clk, i_rst_n,
                    r_state == S_ROLL && step && r_cnt == LAST, r_head == '0 && r_wiped)

endmodule

// ===== rtl/airtime_window_accumulator.sv =====
// a sample runs the roll loop, then reads and banks the head bucket unless the window was
// wiped, then scans the ring; query, clear, the spare command and the first sample go straight to the scan.
// the roll loop advances one bucket per cycle and the scan reads one ring entry per cycle.
// a new item is taken only while idle; busy stays high until the strobe is over.
// the result strobe lasts one cycle; the receiver cannot stall.
// reset (synchronous, active low) empties the ring and sets the bucket length to 60000 ms.
module airtime_window_accumulator import awa_pkg::*; #(
    parameter int NUM_BUCKETS = 60
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [31:0] i_cfg_data,
    output logic        o_cfg_ready,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_now_ms,
    input  logic [31:0] i_total_tx_ms,
    input  logic [31:0] i_total_rx_ms,
    input  logic [7:0]  i_bucket_index,
    input  logic        i_stacked_max,
    output logic        o_valid,
    output logic [15:0] o_tx_bucket_ms,
    output logic [15:0] o_rx_bucket_ms,
    output logic [21:0] o_tx_window_ms,
    output logic [21:0] o_rx_window_ms,
    output logic [15:0] o_max_bucket_ms,
    output logic        o_history_wiped
);

    logic [31:0] r_slot_len;
    logic [31:0] len;
    t_ring_cmd   ring_cmd;
    t_ring_rd    ring_rd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_len <= 32'd60000;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_slot_len <= i_cfg_data;
        end
    end

    // a zero length counts as one
    assign len = (r_slot_len == 32'd0) ? 32'd1 : r_slot_len;

    awa_ring #(.NUM_BUCKETS(NUM_BUCKETS)) u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (ring_cmd),
        .o_rd    (ring_rd)
    );

    awa_ctrl #(.NUM_BUCKETS(NUM_BUCKETS)) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_len           (len),
        .i_start         (start),
        .i_cmd           (i_cmd),
        .i_now_ms        (i_now_ms),
        .i_total_tx_ms   (i_total_tx_ms),
        .i_total_rx_ms   (i_total_rx_ms),
        .i_bucket_index  (i_bucket_index),
        .i_stacked_max   (i_stacked_max),
        .i_rd            (ring_rd),
        .o_ring          (ring_cmd),
        .o_busy          (busy),
        .o_valid         (o_valid),
        .o_tx_bucket_ms  (o_tx_bucket_ms),
        .o_rx_bucket_ms  (o_rx_bucket_ms),
        .o_tx_window_ms  (o_tx_window_ms),
        .o_rx_window_ms  (o_rx_window_ms),
        .o_max_bucket_ms (o_max_bucket_ms),
        .o_history_wiped (o_history_wiped)
    );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// testbench for airtime_window_accumulator: directed and random sample, query, clear and spare items
// depends on awa_pkg and the rtl top level; predicts each result in a small scoreboard class
module testbench;
    import awa_pkg::*;

    localparam int NB = 60;
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int DRAIN_CYCLES = 2 * NB + 10;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [15:0] tx_bucket;
        logic [15:0] rx_bucket;
        logic [21:0] tx_window;
        logic [21:0] rx_window;
        logic [15:0] max_bucket;
        logic        wiped;
    } t_airtime;

    class t_airtime_scoreboard;
        logic [15:0] tx_bank[NB];
        logic [15:0] rx_bank[NB];
        int unsigned head;
        bit          primed;
        logic [31:0] begin_ms;
        logic [31:0] last_tx;
        logic [31:0] last_rx;
        logic [31:0] len_ms;
        t_airtime    pending_q[$];
        int          errors;

        function void empty_ring();
            foreach (tx_bank[k]) begin
                tx_bank[k] = '0;
                rx_bank[k] = '0;
            end
            head = 0;
        endfunction

        function void restart();
            empty_ring();
            primed = 0;
            begin_ms = '0;
            last_tx = '0;
            last_rx = '0;
        endfunction

        function new();
            restart();
            len_ms = 32'd60000;
            errors = 0;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function logic [15:0] add_sat(logic [15:0] a, logic [31:0] b);
            logic [32:0] s;
            s = {17'd0, a} + {1'b0, b};
            return (s > 33'h0FFFF) ? SAT16 : s[15:0];
        endfunction

        // advance the bucket clock, true when the gap spans the whole window
        function bit roll(logic [31:0] now);
            logic [31:0] len;
            logic [31:0] elapsed;
            logic [31:0] steps;
            logic [63:0] span;
            len = (len_ms == 0) ? 32'd1 : len_ms;
            elapsed = now - begin_ms;
            if (elapsed < len) return 0;
            steps = elapsed / len;
            if (steps >= NB) begin
                empty_ring();
                begin_ms = now;
                return 1;
            end
            for (int k = 0; k < steps; k++) begin
                head = (head + 1) % NB;
                tx_bank[head] = '0;
                rx_bank[head] = '0;
            end
            span = 64'(steps) * 64'(len);
            begin_ms = begin_ms + span[31:0];
            return 0;
        endfunction

        function void note(logic [1:0] cmd, logic [31:0] now, logic [31:0] ttx,
                           logic [31:0] trx, logic [7:0] idx, logic stacked);
            t_airtime e;
            logic [31:0] dtx, drx, txs, rxs, mx, v;
            int unsigned slot;
            e.wiped = 0;
            if (cmd == CMD_CLEAR) begin
                restart();
            end else if (cmd == CMD_SAMPLE) begin
                if (!primed) begin
                    primed = 1;
                    begin_ms = now;
                    last_tx = ttx;
                    last_rx = trx;
                end else begin
                    e.wiped = roll(now);
                    dtx = (ttx >= last_tx) ? ttx - last_tx : 32'd0;
                    drx = (trx >= last_rx) ? trx - last_rx : 32'd0;
                    last_tx = ttx;
                    last_rx = trx;
                    if (!e.wiped) begin
                        tx_bank[head] = add_sat(tx_bank[head], dtx);
                        rx_bank[head] = add_sat(rx_bank[head], drx);
                    end
                end
            end
            e.tx_bucket = '0;
            e.rx_bucket = '0;
            if (idx < NB) begin
                slot = (head + 1 + idx) % NB;
                e.tx_bucket = tx_bank[slot];
                e.rx_bucket = rx_bank[slot];
            end
            txs = 0;
            rxs = 0;
            mx = 1;
            for (int k = 0; k < NB; k++) begin
                txs += tx_bank[k];
                rxs += rx_bank[k];
                if (stacked) v = tx_bank[k] + rx_bank[k];
                else v = (rx_bank[k] > tx_bank[k]) ? rx_bank[k] : tx_bank[k];
                if (v > mx) mx = v;
            end
            e.tx_window = (txs > SAT22) ? SAT22 : txs[21:0];
            e.rx_window = (rxs > SAT22) ? SAT22 : rxs[21:0];
            e.max_bucket = (mx > SAT16) ? SAT16 : mx[15:0];
            pending_q.push_back(e);
        endfunction

        task check(t_airtime got);
            t_airtime e;
            if (pending_q.size() == 0) begin
                report("result strobe with no item outstanding");
                return;
            end
            e = pending_q.pop_front();
            if (got.tx_bucket !== e.tx_bucket)
                report($sformatf("tx_bucket %0d exp %0d", got.tx_bucket, e.tx_bucket));
            if (got.rx_bucket !== e.rx_bucket)
                report($sformatf("rx_bucket %0d exp %0d", got.rx_bucket, e.rx_bucket));
            if (got.tx_window !== e.tx_window)
                report($sformatf("tx_window %0d exp %0d", got.tx_window, e.tx_window));
            if (got.rx_window !== e.rx_window)
                report($sformatf("rx_window %0d exp %0d", got.rx_window, e.rx_window));
            if (got.max_bucket !== e.max_bucket)
                report($sformatf("max_bucket %0d exp %0d", got.max_bucket, e.max_bucket));
            if (got.wiped !== e.wiped)
                report($sformatf("history_wiped %0b exp %0b", got.wiped, e.wiped));
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_valid = 0;
    logic [31:0] i_cfg_data = '0;
    logic        o_cfg_ready;
    logic        start = 0;
    logic        busy;
    logic [1:0]  i_cmd = CMD_QUERY;
    logic [31:0] i_now_ms = '0;
    logic [31:0] i_total_tx_ms = '0;
    logic [31:0] i_total_rx_ms = '0;
    logic [7:0]  i_bucket_index = '0;
    logic        i_stacked_max = 0;
    logic        o_valid;
    logic [15:0] o_tx_bucket_ms;
    logic [15:0] o_rx_bucket_ms;
    logic [21:0] o_tx_window_ms;
    logic [21:0] o_rx_window_ms;
    logic [15:0] o_max_bucket_ms;
    logic        o_history_wiped;

    airtime_window_accumulator #(.NUM_BUCKETS(NB)) uut (.*);

    t_airtime_scoreboard sb = new();
    int          cycles = 0;
    int          idle_pct = 0;
    logic [31:0] clock_ms = 32'd1000;
    logic [31:0] tx_total = '0;
    logic [31:0] rx_total = '0;

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_airtime got;
        if (i_rst_n && o_valid) begin
            got.tx_bucket = o_tx_bucket_ms;
            got.rx_bucket = o_rx_bucket_ms;
            got.tx_window = o_tx_window_ms;
            got.rx_window = o_rx_window_ms;
            got.max_bucket = o_max_bucket_ms;
            got.wiped = o_history_wiped;
            sb.check(got);
        end
    end

    task automatic write_len(logic [31:0] len);
        @(negedge i_clk);
        i_cfg_valid = 1;
        i_cfg_data = len;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.len_ms = len;
        @(negedge i_clk);
        i_cfg_valid = 0;
    endtask

    // drive one item; start drops at the next falling edge unless another follows
    task automatic issue(logic [1:0] cmd, logic [31:0] now, logic [31:0] ttx,
                         logic [31:0] trx, logic [7:0] idx, logic stacked);
        while ($urandom_range(0, 99) < idle_pct) begin
            start = 0;
            @(negedge i_clk);
        end
        start = 1;
        i_cmd = cmd;
        i_now_ms = now;
        i_total_tx_ms = ttx;
        i_total_rx_ms = trx;
        i_bucket_index = idx;
        i_stacked_max = stacked;
        do @(posedge i_clk); while (busy);
        sb.note(cmd, now, ttx, trx, idx, stacked);
        @(negedge i_clk);
        start = 0;
    endtask

    task automatic settle();
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_item();
        logic [31:0] len;
        logic [63:0] step;
        int r;
        len = (sb.len_ms == 0) ? 32'd1 : sb.len_ms;
        r = $urandom_range(0, 99);
        if (r < 55) step = 64'($urandom) % (64'(len) * 3 + 1);
        else if (r < 75) step = 64'($urandom) % (64'(len) / 4 + 1);
        else if (r < 85) step = 64'(len) * $urandom_range(NB - 2, NB + 8);
        else step = 64'($urandom);
        clock_ms = clock_ms + step[31:0];
        r = $urandom_range(0, 99);
        if (r < 80) begin
            tx_total += $urandom_range(0, 3000);
            rx_total += $urandom_range(0, 3000);
        end else if (r < 88) begin
            tx_total -= $urandom_range(0, 5000);
            rx_total += $urandom_range(0, 500);
        end else if (r < 94) begin
            tx_total += $urandom_range(60000, 70000);
            rx_total -= $urandom_range(0, 5000);
        end else begin
            tx_total = $urandom;
            rx_total = $urandom;
        end
        r = $urandom_range(0, 99);
        issue(r < 78 ? CMD_SAMPLE : r < 90 ? CMD_QUERY : r < 96 ? CMD_SPARE : CMD_CLEAR,
              clock_ms, tx_total, rx_total,
              $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, NB - 1)),
              1'($urandom_range(0, 1)));
    endtask

    logic [31:0] lens[6] = '{32'd60000, 32'd1, 32'd0, 32'hFFFFFFFF, 32'd10, 32'd250};

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n = 1;

        // directed: baseline, saturation, backwards totals, index range, wipe, clear
        write_len(32'd100);
        issue(CMD_QUERY, 32'd0, 32'd0, 32'd0, 8'd0, 1'b0);
        issue(CMD_SAMPLE, 32'hFFFFFF00, 32'd0, 32'd0, 8'd0, 1'b0);
        issue(CMD_SAMPLE, 32'hFFFFFF10, 32'hFFFFFFFF, 32'd500, 8'd59, 1'b0);
        issue(CMD_SAMPLE, 32'h00000020, 32'd5, 32'd900, 8'd58, 1'b1);
        issue(CMD_SAMPLE, 32'h00000090, 32'd105, 32'd100, 8'd59, 1'b1);
        issue(CMD_QUERY, 32'd0, 32'd0, 32'd0, 8'd60, 1'b0);
        issue(CMD_SPARE, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'd255, 1'b1);
        issue(CMD_QUERY, 32'd0, 32'd0, 32'd0, 8'd57, 1'b0);
        issue(CMD_SAMPLE, 32'h00002000, 32'd200, 32'd300, 8'd59, 1'b0);
        issue(CMD_SAMPLE, 32'h00002010, 32'd65800, 32'd70000, 8'd59, 1'b1);
        issue(CMD_SAMPLE, 32'h00002400, 32'd65900, 32'd70100, 8'd0, 1'b0);
        issue(CMD_CLEAR, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 8'hAA, 1'b1);
        issue(CMD_SAMPLE, 32'h55555555, 32'hAAAAAAAA, 32'h55555555, 8'h55, 1'b0);
        issue(CMD_SAMPLE, 32'h555555AA, 32'hAAAAAAFF, 32'h55555600, 8'd59, 1'b0);
        clock_ms = 32'h555555AA;
        tx_total = 32'hAAAAAAFF;
        rx_total = 32'h55555600;
        settle();

        foreach (lens[p]) begin
            write_len(lens[p]);
            for (int q = 0; q < 4; q++) begin
                idle_pct = (q == 1) ? 66 : (q == 3) ? 35 : 0;
                repeat (56) random_item();
            end
            settle();
        end

        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/awa_pkg.sv
rtl/awa_ring.sv
rtl/awa_ctrl.sv
rtl/airtime_window_accumulator.sv
tb/testbench.sv
